### rtl/box_frustum_cull_top_macros.svh
// Assertion macros for the box frustum cull block
`ifndef BOX_FRUSTUM_CULL_TOP_MACROS_SVH
`define BOX_FRUSTUM_CULL_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define BFC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked from a fixed number of cycles later
`define BFC_ASSERT_DLY(lbl, clk, rst, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### rtl/bfc_pkg.sv
// Shared types and constants for the box frustum cull block
`default_nettype none

package bfc_pkg;

   localparam int unsigned CORNER_COUNT      = 8;
   localparam int unsigned COORD_BITS_DEF    = 16;
   localparam int unsigned MATRIX_BITS       = 16;
   localparam int unsigned MATRIX_DIM        = 4;
   localparam int unsigned CORNER_FIELD_BITS = 48;
   localparam int unsigned PLANE_COUNT       = 6;
   // homogeneous w = 1.0 in Q8 is a left shift by the fraction width
   localparam int unsigned ONE_SHIFT         = 8;
   // start beat to result strobe: product, sum, plane test, merge
   localparam int unsigned LATENCY           = 4;

   typedef logic [MATRIX_DIM-1:0][MATRIX_DIM-1:0][MATRIX_BITS-1:0] mat_type;
   typedef logic [PLANE_COUNT-1:0] plane_mask_type;

endpackage

`default_nettype wire

### rtl/bfc_lane.sv
// One corner lane: clip-space transform and six-plane outside test
`default_nettype none

module bfc_lane
   import bfc_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  mat_type                      matrix,
   input  logic [CORNER_FIELD_BITS-1:0] corner,
   output plane_mask_type               planes
);

   localparam int unsigned EXT_BITS  = (3 * COORD_BITS > CORNER_FIELD_BITS) ?
                                       3 * COORD_BITS : CORNER_FIELD_BITS;
   localparam int unsigned PROD_BITS = MATRIX_BITS + COORD_BITS;
   localparam int unsigned SUM_BITS  = PROD_BITS + 2;
   localparam int unsigned CMP_BITS  = SUM_BITS + 1;

   // coordinate bits beyond the corner field read as zero
   logic [EXT_BITS-1:0]         corner_ext;
   logic signed [COORD_BITS-1:0] coord [3];

   logic signed [PROD_BITS-1:0]   prod_in  [MATRIX_DIM][3];
   logic signed [PROD_BITS-1:0]   prod_ff  [MATRIX_DIM][3];
   logic signed [MATRIX_BITS-1:0] wcol_ff  [MATRIX_DIM];
   logic signed [SUM_BITS-1:0]    q_in     [MATRIX_DIM];
   logic signed [SUM_BITS-1:0]    q_ff     [MATRIX_DIM];
   logic signed [CMP_BITS-1:0]    lo_sum   [3];
   logic signed [CMP_BITS-1:0]    hi_diff  [3];
   plane_mask_type                planes_in;
   plane_mask_type                planes_ff;

   assign corner_ext = EXT_BITS'(corner);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coord[k] = corner_ext[k*COORD_BITS +: COORD_BITS];
      end
   end

   // stage 1: matrix times x, y, z
   always_comb begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(matrix[r][c]) * coord[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r][c] <= prod_in[r][c];
         end
         wcol_ff[r] <= $signed(matrix[r][MATRIX_DIM-1]);
      end
   end

   // stage 2: row sums, w column scaled by one
   always_comb begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
         q_in[r] = SUM_BITS'(prod_ff[r][0]) + SUM_BITS'(prod_ff[r][1]) +
                   SUM_BITS'(prod_ff[r][2]) + (SUM_BITS'(wcol_ff[r]) <<< ONE_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < MATRIX_DIM; r++) begin
         q_ff[r] <= q_in[r];
      end
   end

   // stage 3: q < -w via sign of q + w, q > w via sign of w - q
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_sum[k]  = CMP_BITS'(q_ff[k]) + CMP_BITS'(q_ff[MATRIX_DIM-1]);
         hi_diff[k] = CMP_BITS'(q_ff[MATRIX_DIM-1]) - CMP_BITS'(q_ff[k]);
         planes_in[2*k]     = lo_sum[k][CMP_BITS-1];
         planes_in[2*k + 1] = hi_diff[k][CMP_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      planes_ff <= planes_in;
   end

   assign planes = planes_ff;

endmodule

`default_nettype wire

### rtl/bfc_merge.sv
// Merge of lane plane masks into the cull decision
`default_nettype none

module bfc_merge
   import bfc_pkg::*;
(
   input  logic           clock,
   input  plane_mask_type lane_planes [CORNER_COUNT],
   output logic           visible,
   output plane_mask_type outside_planes
);

   plane_mask_type all_in;
   plane_mask_type all_ff;
   logic           visible_ff;

   always_comb begin
      all_in = '1;
      for (int k = 0; k < CORNER_COUNT; k++) begin
         all_in = all_in & lane_planes[k];
      end
   end

   always_ff @(posedge clock) begin
      all_ff     <= all_in;
      visible_ff <= (all_in == '0);
   end

   assign visible        = visible_ff;
   assign outside_planes = all_ff;

endmodule

`default_nettype wire

### rtl/box_frustum_cull_top.sv
// Top level of the clip-space bounding box frustum cull block
//
// Usage:
//  - Request: drive the four matrix rows and eight box corners on req_*
//    and raise start; a beat is taken at each edge with start high and
//    busy low. busy stays low, so a new box may follow every cycle.
//  - Response: rsp_valid strobes for one cycle with rsp_visible and
//    rsp_outside_planes (left, right, bottom, top, near, far in bits 0..5).
//  - Throughput: one box per cycle; the result passes through the product,
//    row sum, plane test and merge registers in that order.
//  - The pipeline: 8 corner lanes (multiply, row sum, plane test) then an
//    AND merge across lanes. Multipliers are 16 x COORD_BITS, one per matrix
//    entry in the x, y, z columns, per lane.
//  - The receiver cannot stall: every strobe is a delivered beat.
//  - Reset (synchronous) clears the strobe pipeline; beats in flight are
//    dropped. Payload registers are not reset.
`default_nettype none

module box_frustum_cull_top
   import bfc_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [63:0]                  req_matrix_row_0,
   input  logic [63:0]                  req_matrix_row_1,
   input  logic [63:0]                  req_matrix_row_2,
   input  logic [63:0]                  req_matrix_row_3,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_0,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_1,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_2,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_3,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_4,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_5,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_6,
   input  logic [CORNER_FIELD_BITS-1:0] req_corner_7,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   output logic [PLANE_COUNT-1:0]       rsp_outside_planes
);

   mat_type                      matrix;
   logic [CORNER_FIELD_BITS-1:0] corners [CORNER_COUNT];
   plane_mask_type               lane_planes [CORNER_COUNT];
   logic [LATENCY-1:0]           valid_ff;
   logic [LATENCY-1:0]           valid_in;

   // the pipeline has no stall, so the block never holds a beat off
   assign busy = 1'b0;

   assign matrix[0] = req_matrix_row_0;
   assign matrix[1] = req_matrix_row_1;
   assign matrix[2] = req_matrix_row_2;
   assign matrix[3] = req_matrix_row_3;

   assign corners[0] = req_corner_0;
   assign corners[1] = req_corner_1;
   assign corners[2] = req_corner_2;
   assign corners[3] = req_corner_3;
   assign corners[4] = req_corner_4;
   assign corners[5] = req_corner_5;
   assign corners[6] = req_corner_6;
   assign corners[7] = req_corner_7;

   // one lane per corner, all fed the same matrix
   for (genvar g = 0; g < CORNER_COUNT; g++) begin : g_lane
      bfc_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock  (clock),
         .matrix (matrix),
         .corner (corners[g]),
         .planes (lane_planes[g])
      );
   end

   bfc_merge u_merge (
      .clock          (clock),
      .lane_planes    (lane_planes),
      .visible        (rsp_visible),
      .outside_planes (rsp_outside_planes)
   );

   // strobe travels alongside the payload stages
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

endmodule

`default_nettype wire

### rtl/bfc_checker.sv
// Port-level checker for the box frustum cull block, bound to the top level
`default_nettype none
`include "box_frustum_cull_top_macros.svh"

module bfc_checker
   import bfc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic                   rsp_visible,
   input logic [PLANE_COUNT-1:0] rsp_outside_planes
);

   `BFC_ASSERT_DLY(a_beat_answered, clock, reset, start && !busy, 4, rsp_valid, "accepted beat gave no result")
   `BFC_ASSERT_IMP(a_no_stray_rsp, clock, reset, rsp_valid, $past(start && !busy, 4), "result without a beat")
   `BFC_ASSERT_IMP(a_visible_mask, clock, reset, rsp_valid, rsp_visible == (rsp_outside_planes == '0), "visible disagrees with mask")
   `BFC_ASSERT_IMP(a_never_busy, clock, reset, start, !busy, "block refused a beat")

endmodule

bind box_frustum_cull_top bfc_checker u_bfc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_visible        (rsp_visible),
   .rsp_outside_planes (rsp_outside_planes)
);

`default_nettype wire

### verif/tb_box_frustum_cull_top.sv
// Self-checking testbench for the clip-space bounding box frustum cull block
`timescale 1ns / 100ps

module tb_box_frustum_cull_top;
   import bfc_pkg::*;

   // coordinate width of the instance; the box builders below pack x,y,z at 16 bits
   localparam int unsigned COORD_W = COORD_BITS_DEF;
   localparam int unsigned DIR_N   = 21;
   localparam int unsigned RAND_PER_PHASE = 250;

   // one bit per clip plane, in the order of rsp_outside_planes
   localparam plane_mask_type CUT_NONE   = 6'h00;
   localparam plane_mask_type CUT_LEFT   = 6'h01;
   localparam plane_mask_type CUT_RIGHT  = 6'h02;
   localparam plane_mask_type CUT_BOTTOM = 6'h04;
   localparam plane_mask_type CUT_TOP    = 6'h08;
   localparam plane_mask_type CUT_NEAR   = 6'h10;
   localparam plane_mask_type CUT_FAR    = 6'h20;
   localparam plane_mask_type CUT_ALL    = 6'h3F;

   // Q7.8 values used by the directed rows
   localparam logic [15:0] Q_ZERO      = 16'h0000;
   localparam logic [15:0] Q_HALF      = 16'h0080;
   localparam logic [15:0] Q_NEG_HALF  = 16'hFF80;
   localparam logic [15:0] Q_ONE       = 16'h0100;
   localparam logic [15:0] Q_NEG_ONE   = 16'hFF00;
   localparam logic [15:0] Q_TWO       = 16'h0200;
   localparam logic [15:0] Q_NEG_TWO   = 16'hFE00;
   localparam logic [15:0] Q_THREE     = 16'h0300;
   localparam logic [15:0] Q_NEG_THREE = 16'hFD00;
   localparam logic [15:0] Q_MAX       = 16'h7FFF;
   localparam logic [15:0] Q_MIN       = 16'h8000;
   localparam logic [15:0] Q_ALL       = 16'hFFFF;

   // matrices, row 3 first so that index [r] is row r
   localparam mat_type MAT_IDENT = {64'h0100_0000_0000_0000, 64'h0000_0100_0000_0000,
                                    64'h0000_0000_0100_0000, 64'h0000_0000_0000_0100};
   localparam mat_type MAT_ZERO  = '0;
   localparam mat_type MAT_ONES  = '1;
   localparam mat_type MAT_MIN   = {16{16'h8000}};
   localparam mat_type MAT_MAX   = {16{16'h7FFF}};
   // only w is produced, and it is -1.0 for every corner
   localparam mat_type MAT_NEG_W = {64'hFF00_0000_0000_0000, 192'h0};
   // x,y,z pass through, w is always zero
   localparam mat_type MAT_NO_W  = {64'h0, MAT_IDENT[2:0]};
   localparam mat_type MAT_FLIP_W = {64'hFF00_0000_0000_0000, MAT_IDENT[2:0]};
   localparam mat_type MAT_MAX_W = {{4{16'h7FFF}}, 192'h0};
   // rough perspective projection, w taken from -z
   localparam mat_type MAT_PERSP = {64'h0000_FF00_0000_0000, 64'hFE00_FEF0_0000_0000,
                                    64'h0000_0000_0266_0000, 64'h0000_0000_0000_01B5};

   typedef logic [CORNER_COUNT-1:0][CORNER_FIELD_BITS-1:0] corner_set_type;

   typedef struct packed {
      logic           visible;
      plane_mask_type planes;
   } cull_result_type;

   // directed row: matrix, box extents as {z,y,x}, and a typed-in verdict where known
   typedef struct packed {
      mat_type                      mat;
      logic [CORNER_FIELD_BITS-1:0] lo;
      logic [CORNER_FIELD_BITS-1:0] hi;
      logic                         known;
      cull_result_type              want;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   logic rsp_visible;
   plane_mask_type rsp_outside_planes;

   mat_type         drv_mat   = '0;
   corner_set_type  drv_box   = '0;
   logic            drv_known = 1'b0;
   cull_result_type drv_want  = '0;

   // newest verdict at the front, oldest at the back
   cull_result_type verdict_q[$];
   probe_row_type   probe_tab[DIR_N];

   int unsigned gap_pct = 34;
   int unsigned boxes_sent = 0;
   int unsigned verdicts_seen = 0;
   int unsigned culled_seen = 0;
   int unsigned errors = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   box_frustum_cull_top #(
      .COORD_BITS(COORD_W)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_matrix_row_0   (drv_mat[0]),
      .req_matrix_row_1   (drv_mat[1]),
      .req_matrix_row_2   (drv_mat[2]),
      .req_matrix_row_3   (drv_mat[3]),
      .req_corner_0       (drv_box[0]),
      .req_corner_1       (drv_box[1]),
      .req_corner_2       (drv_box[2]),
      .req_corner_3       (drv_box[3]),
      .req_corner_4       (drv_box[4]),
      .req_corner_5       (drv_box[5]),
      .req_corner_6       (drv_box[6]),
      .req_corner_7       (drv_box[7]),
      .rsp_valid          (rsp_valid),
      .rsp_visible        (rsp_visible),
      .rsp_outside_planes (rsp_outside_planes)
   );

   // Clip-space verdict for one box. Every corner (x,y,z,1) goes through the
   // matrix with exact 64-bit sums; a plane survives only if every corner is
   // strictly beyond it, so a corner sitting on a plane keeps the box in.
   function automatic cull_result_type cull_verdict(input mat_type mat,
                                                    input corner_set_type box);
      longint m[4][4];
      longint p[4];
      longint q[4];
      logic [63:0] word;
      plane_mask_type hits;
      plane_mask_type all_out;
      cull_result_type res;
      all_out = CUT_ALL;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            m[r][c] = $signed(mat[r][c]);
      for (int k = 0; k < CORNER_COUNT; k++) begin
         // coordinate bits beyond the 48-bit field read as zero
         for (int a = 0; a < 3; a++) begin
            word = 64'(box[k]) >> (a * COORD_W);
            word = word << (64 - COORD_W);
            p[a] = $signed(word) >>> (64 - COORD_W);
         end
         p[3] = 64'sd1 << ONE_SHIFT;
         for (int r = 0; r < 4; r++) begin
            q[r] = 0;
            for (int c = 0; c < 4; c++)
               q[r] += m[r][c] * p[c];
         end
         hits = CUT_NONE;
         if (q[0] < -q[3]) hits |= CUT_LEFT;
         if (q[0] >  q[3]) hits |= CUT_RIGHT;
         if (q[1] < -q[3]) hits |= CUT_BOTTOM;
         if (q[1] >  q[3]) hits |= CUT_TOP;
         if (q[2] < -q[3]) hits |= CUT_NEAR;
         if (q[2] >  q[3]) hits |= CUT_FAR;
         all_out &= hits;
      end
      res.visible = (all_out == CUT_NONE);
      res.planes  = all_out;
      return res;
   endfunction

   function automatic logic [CORNER_FIELD_BITS-1:0] xyz(input logic [15:0] x,
                                                        input logic [15:0] y,
                                                        input logic [15:0] z);
      return {z, y, x};
   endfunction

   // axis-aligned box: corner k takes hi on x, y, z where bit 0, 1, 2 of k is set
   function automatic corner_set_type corners_of_box(input logic [CORNER_FIELD_BITS-1:0] lo,
                                                     input logic [CORNER_FIELD_BITS-1:0] hi);
      corner_set_type box;
      for (int k = 0; k < CORNER_COUNT; k++)
         box[k] = {(k & 4) ? hi[47:32] : lo[47:32],
                   (k & 2) ? hi[31:16] : lo[31:16],
                   (k & 1) ? hi[15:0]  : lo[15:0]};
      return box;
   endfunction

   // signed Q7.8 value in [-span, span] LSBs
   function automatic logic [15:0] q8_near(input int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Idle the request side per gap_pct, then present one box and hold it until
   // taken. start is only ever assigned once per edge.
   task automatic send_box(input mat_type mat, input corner_set_type box,
                           input logic known, input cull_result_type want);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      drv_mat   <= mat;
      drv_box   <= box;
      drv_known <= known;
      drv_want  <= want;
      start     <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      boxes_sent++;
   endtask

   // Request side: every beat taken is turned into an expected verdict here,
   // either the typed-in one of a directed row or the predicted one.
   // Response side: each strobe is one beat and is checked on the spot.
   always @(posedge clock) begin
      cull_result_type want_now;
      if (!reset && start && !busy) begin
         if (drv_known)
            verdict_q.push_front(drv_want);
         else
            verdict_q.push_front(cull_verdict(drv_mat, drv_box));
      end
      if (!reset && rsp_valid) begin
         verdicts_seen++;
         if (!rsp_visible)
            culled_seen++;
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got visible %0b planes %02h",
                     $time, rsp_visible, rsp_outside_planes);
            errors++;
         end else begin
            want_now = verdict_q.pop_back();
            if (rsp_visible !== want_now.visible) begin
               $display("%0t: visible expected %0b got %0b",
                        $time, want_now.visible, rsp_visible);
               errors++;
            end
            if (rsp_outside_planes !== want_now.planes) begin
               $display("%0t: outside_planes expected %02h got %02h",
                        $time, want_now.planes, rsp_outside_planes);
               errors++;
            end
         end
      end
   end

   initial begin
      mat_type mat;
      corner_set_type box;
      logic [CORNER_FIELD_BITS-1:0] lo_v;
      logic [CORNER_FIELD_BITS-1:0] hi_v;
      logic [15:0] lo_c;
      int unsigned drain;
      int unsigned phase_gap[3];

      // Directed rows. Plane hits are read straight off an identity matrix,
      // where w is 1.0 and a coordinate beyond +-1.0 is outside.
      probe_tab[0]  = {MAT_IDENT, xyz(Q_NEG_HALF, Q_NEG_HALF, Q_NEG_HALF),
                       xyz(Q_HALF, Q_HALF, Q_HALF), 1'b1, 1'b1, CUT_NONE};
      probe_tab[1]  = {MAT_IDENT, xyz(Q_TWO, Q_ZERO, Q_ZERO),
                       xyz(Q_TWO, Q_ZERO, Q_ZERO), 1'b1, 1'b0, CUT_RIGHT};
      probe_tab[2]  = {MAT_IDENT, xyz(Q_NEG_TWO, Q_ZERO, Q_ZERO),
                       xyz(Q_NEG_TWO, Q_ZERO, Q_ZERO), 1'b1, 1'b0, CUT_LEFT};
      probe_tab[3]  = {MAT_IDENT, xyz(Q_ZERO, Q_TWO, Q_ZERO),
                       xyz(Q_ZERO, Q_TWO, Q_ZERO), 1'b1, 1'b0, CUT_TOP};
      probe_tab[4]  = {MAT_IDENT, xyz(Q_ZERO, Q_NEG_TWO, Q_ZERO),
                       xyz(Q_ZERO, Q_NEG_TWO, Q_ZERO), 1'b1, 1'b0, CUT_BOTTOM};
      probe_tab[5]  = {MAT_IDENT, xyz(Q_ZERO, Q_ZERO, Q_TWO),
                       xyz(Q_ZERO, Q_ZERO, Q_TWO), 1'b1, 1'b0, CUT_FAR};
      probe_tab[6]  = {MAT_IDENT, xyz(Q_ZERO, Q_ZERO, Q_NEG_TWO),
                       xyz(Q_ZERO, Q_ZERO, Q_NEG_TWO), 1'b1, 1'b0, CUT_NEAR};
      // corners exactly on the right and left planes count as inside
      probe_tab[7]  = {MAT_IDENT, xyz(Q_ONE, Q_ZERO, Q_ZERO),
                       xyz(Q_ONE, Q_ZERO, Q_ZERO), 1'b1, 1'b1, CUT_NONE};
      probe_tab[8]  = {MAT_IDENT, xyz(Q_NEG_ONE, Q_ZERO, Q_ZERO),
                       xyz(Q_NEG_ONE, Q_ZERO, Q_ZERO), 1'b1, 1'b1, CUT_NONE};
      // half the corners out left, half out right: no single plane culls
      probe_tab[9]  = {MAT_IDENT, xyz(Q_NEG_TWO, Q_ZERO, Q_ZERO),
                       xyz(Q_TWO, Q_ZERO, Q_ZERO), 1'b1, 1'b1, CUT_NONE};
      probe_tab[10] = {MAT_ZERO, xyz(Q_MIN, Q_MIN, Q_MIN),
                       xyz(Q_MAX, Q_MAX, Q_MAX), 1'b1, 1'b1, CUT_NONE};
      // w = -1: the origin is beyond all six planes at once
      probe_tab[11] = {MAT_NEG_W, xyz(Q_ZERO, Q_ZERO, Q_ZERO),
                       xyz(Q_ZERO, Q_ZERO, Q_ZERO), 1'b1, 1'b0, CUT_ALL};
      probe_tab[12] = {MAT_NO_W, xyz(Q_ZERO, Q_ZERO, Q_ZERO),
                       xyz(Q_ZERO, Q_ZERO, Q_ZERO), 1'b1, 1'b1, CUT_NONE};
      probe_tab[13] = {MAT_IDENT, xyz(Q_TWO, Q_NEG_THREE, Q_ZERO),
                       xyz(Q_THREE, Q_NEG_TWO, Q_ZERO), 1'b1, 1'b0, CUT_RIGHT | CUT_BOTTOM};
      // field extremes and odd matrices go through the predictor
      probe_tab[14] = {MAT_ONES, xyz(Q_ALL, Q_ALL, Q_ALL),
                       xyz(Q_ALL, Q_ALL, Q_ALL), 1'b0, 1'b0, CUT_NONE};
      probe_tab[15] = {MAT_MIN, xyz(Q_MIN, Q_MIN, Q_MIN),
                       xyz(Q_MIN, Q_MIN, Q_MIN), 1'b0, 1'b0, CUT_NONE};
      probe_tab[16] = {MAT_MAX, xyz(Q_MAX, Q_MAX, Q_MAX),
                       xyz(Q_MAX, Q_MAX, Q_MAX), 1'b0, 1'b0, CUT_NONE};
      probe_tab[17] = {MAT_MIN, xyz(Q_MAX, Q_MAX, Q_MAX),
                       xyz(Q_MAX, Q_MAX, Q_MAX), 1'b0, 1'b0, CUT_NONE};
      probe_tab[18] = {MAT_MAX_W, xyz(Q_MIN, Q_MIN, Q_MIN),
                       xyz(Q_MAX, Q_MAX, Q_MAX), 1'b0, 1'b0, CUT_NONE};
      probe_tab[19] = {MAT_PERSP, xyz(Q_NEG_TWO, Q_NEG_TWO, Q_NEG_THREE),
                       xyz(Q_TWO, Q_TWO, Q_NEG_ONE), 1'b0, 1'b0, CUT_NONE};
      probe_tab[20] = {MAT_FLIP_W, xyz(Q_NEG_HALF, Q_NEG_HALF, Q_NEG_HALF),
                       xyz(Q_HALF, Q_HALF, Q_HALF), 1'b0, 1'b0, CUT_NONE};

      // sender gap per random phase: light, heavy, then back to back
      phase_gap[0] = 34;
      phase_gap[1] = 83;
      phase_gap[2] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      gap_pct = phase_gap[0];
      for (int i = 0; i < DIR_N; i++)
         send_box(probe_tab[i].mat, corners_of_box(probe_tab[i].lo, probe_tab[i].hi),
                  probe_tab[i].known, probe_tab[i].want);

      // Random boxes. Most are near-identity transforms with a translation and
      // a box of modest size, so both culled and visible verdicts turn up;
      // the rest use raw random rows or corners to toggle every input bit.
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct = phase_gap[ph];
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               mat = {$urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom()};
            end else begin
               for (int r = 0; r < 4; r++)
                  for (int c = 0; c < 4; c++)
                     mat[r][c] = q8_near(32);
               for (int r = 0; r < 3; r++) begin
                  mat[r][r] = 16'($urandom_range(64, 512));
                  if ($urandom_range(0, 7) == 0)
                     mat[r][r] = -mat[r][r];
                  mat[r][3] = q8_near(1024);
               end
               mat[3][3] = Q_ONE + q8_near(64);
               // now and then a w row that goes negative or vanishes
               if ($urandom_range(0, 15) == 0)
                  mat[3] = {$urandom(), $urandom()};
            end
            if ($urandom_range(0, 4) == 0) begin
               for (int k = 0; k < CORNER_COUNT; k++)
                  box[k] = 48'({$urandom(), $urandom()});
            end else begin
               for (int a = 0; a < 3; a++) begin
                  lo_c = q8_near(1024);
                  lo_v[a*16 +: 16] = lo_c;
                  hi_v[a*16 +: 16] = lo_c + 16'($urandom_range(0, 512));
               end
               box = corners_of_box(lo_v, hi_v);
            end
            send_box(mat, box, 1'b0, '0);
         end
      end
      start <= 1'b0;

      // let the pipeline empty, then wait on for stray strobes
      for (drain = 0; drain < 50 * LATENCY && verdict_q.size() != 0; drain++)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: %0d verdicts expected, none arrived", $time, verdict_q.size());
         errors++;
      end

      $display("Sent %0d boxes (%0d directed), checked %0d verdicts, %0d of them culled",
               boxes_sent, DIR_N, verdicts_seen, culled_seen);
      $display("Sender gaps: 34%% and 83%% of cycles, then back to back; %0d mismatches",
               errors);
      if (errors == 0)
         $display("box_frustum_cull_top verification clean");
      else
         $display("box_frustum_cull_top verification failed");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("box_frustum_cull_top verification failed");
      $finish;
   end

endmodule
